// File: hw/rtl/sbus_frame_receiver_unit_defines.svh
// Assertion macros shared by the SBUS frame receiver RTL.
`ifndef SBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define SBFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbfr: same-cycle check failed");

// Next-cycle implication check.
`define SBFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbfr: next-cycle check failed");

`endif

// File: hw/rtl/sbfr_pkg.sv
// Types and constants of the SBUS frame receiver.
package sbfr_pkg;

   localparam int FRAME_BYTES     = 23;
   localparam int NUM_CHANNELS    = 16;
   localparam int CHAN_BITS       = 11;
   localparam int CHAN_INDEX_BITS = 4;
   localparam int BYTE_BITS       = 8;
   localparam int TIME_BITS       = 32;
   localparam int GAP_BITS        = 16;
   localparam int FLAG_BITS       = 4;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int BYTE_COUNT_BITS = 5;
   localparam int CHAN_FIELD_BITS = (FRAME_BYTES - 1) * BYTE_BITS;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int QUEUE_CNT_BITS  = 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_GAP_TIME = 8'd0;
   localparam csr_index_type CSR_HEADER   = 8'd1;

   localparam logic [GAP_BITS-1:0]        GAP_RESET    = 16'd2000;
   localparam logic [BYTE_BITS-1:0]       HEADER_RESET = 8'h0F;
   localparam logic [BYTE_COUNT_BITS-1:0] LAST_BYTE    = BYTE_COUNT_BITS'(FRAME_BYTES - 1);
   localparam logic [CHAN_INDEX_BITS-1:0] LAST_CHANNEL = CHAN_INDEX_BITS'(NUM_CHANNELS - 1);
   localparam logic [QUEUE_CNT_BITS-1:0]  QUEUE_FULL   = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   typedef struct packed {
      logic [FLAG_BITS-1:0]       flags;
      logic [CHAN_FIELD_BITS-1:0] chans;
   } frame_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

// File: hw/rtl/sbfr_req_if.sv
// Request channel carrying received bytes with their arrival time.
interface sbfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0]  rx_byte;
   logic [31:0] arrival_time_us;

   modport source (output valid, output rx_byte, output arrival_time_us, input ready);
   modport sink   (input valid, input rx_byte, input arrival_time_us, output ready);
endinterface

// File: hw/rtl/sbfr_rsp_if.sv
// Response channel carrying one decoded channel result.
interface sbfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel_index;
   logic [10:0] channel_value;
   logic        digital_one;
   logic        digital_two;
   logic        frame_lost;
   logic        failsafe;
   logic        last_of_frame;

   modport source (output valid, output channel_index, output channel_value,
                   output digital_one, output digital_two, output frame_lost,
                   output failsafe, output last_of_frame, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input digital_one, input digital_two, input frame_lost,
                   input failsafe, input last_of_frame, output ready);
endinterface

// File: hw/rtl/sbfr_csr_if.sv
// Register write channel.
interface sbfr_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/sbus_frame_receiver_unit.sv
// SBUS frame receiver: takes one time-stamped serial byte per request and, in
// hunting mode, syncs on the header byte after a quiet gap longer than
// gap_time_us; the following 23 bytes are collected and the finished frame is
// handed to a two-entry frame queue. The request side accepts one byte per
// cycle and stalls only on the last byte of a frame while both queue entries
// are taken. The back end drains one frame as sixteen responses, one channel
// per cycle while the response side is ready; header matching and gap timing
// take effect in the cycle of the request, while register writes (always
// accepted) are registered before they take effect.
module sbus_frame_receiver_unit (
   input  logic       clock,
   input  logic       reset,
   sbfr_req_if.sink   req_bus,
   sbfr_rsp_if.source rsp_bus,
   sbfr_csr_if.sink   csr_bus
);

   logic                push_valid;
   logic                push_ready;
   sbfr_pkg::frame_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   sbfr_pkg::frame_type pop_data;

   sbfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   sbfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   sbfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: hw/rtl/sbfr_front.sv
// Front end: register file, header hunt with gap timing, frame byte collection.
module sbfr_front (
   input  logic                clock,
   input  logic                reset,
   sbfr_req_if.sink            req_bus,
   sbfr_csr_if.sink            csr_bus,
   output logic                push_valid,
   output sbfr_pkg::frame_type push_data,
   input  logic                push_ready
);

   logic [sbfr_pkg::GAP_BITS-1:0]        gap_time_ff, gap_time_in;
   logic [sbfr_pkg::BYTE_BITS-1:0]       header_ff, header_in;
   logic                                 in_frame_ff, in_frame_in;
   logic [sbfr_pkg::TIME_BITS-1:0]       gap_start_ff, gap_start_in;
   logic [sbfr_pkg::BYTE_COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [sbfr_pkg::CHAN_FIELD_BITS-1:0] store_ff, store_in;

   logic                           last_byte;
   logic                           req_fire;
   logic                           csr_fire;
   logic [sbfr_pkg::TIME_BITS-1:0] elapsed;
   logic                           gap_passed;

   assign last_byte       = in_frame_ff && (byte_count_ff == sbfr_pkg::LAST_BYTE);
   assign req_bus.ready   = !last_byte || push_ready;
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;
   assign csr_fire        = csr_bus.valid && csr_bus.ready;
   assign elapsed         = req_bus.arrival_time_us - gap_start_ff;
   assign gap_passed      = elapsed > {{(sbfr_pkg::TIME_BITS - sbfr_pkg::GAP_BITS){1'b0}},
                                       gap_time_ff};
   assign push_valid      = req_fire && last_byte;
   assign push_data.flags = req_bus.rx_byte[sbfr_pkg::FLAG_BITS-1:0];
   assign push_data.chans = store_ff;

   always_comb begin
      gap_time_in = gap_time_ff;
      header_in   = header_ff;
      if (csr_fire) begin
         unique case (csr_bus.index)
            sbfr_pkg::CSR_GAP_TIME: gap_time_in = csr_bus.data;
            sbfr_pkg::CSR_HEADER:   header_in   = csr_bus.data[sbfr_pkg::BYTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      gap_start_in  = gap_start_ff;
      byte_count_in = byte_count_ff;
      store_in      = store_ff;
      if (req_fire) begin
         if (!in_frame_ff) begin
            if ((req_bus.rx_byte == header_ff) && gap_passed) begin
               in_frame_in   = 1'b1;
               byte_count_in = '0;
            end else begin
               gap_start_in = req_bus.arrival_time_us;
            end
         end else if (last_byte) begin
            in_frame_in   = 1'b0;
            byte_count_in = '0;
            gap_start_in  = req_bus.arrival_time_us;
         end else begin
            byte_count_in = byte_count_ff + 1'b1;
            store_in      = {req_bus.rx_byte,
                             store_ff[sbfr_pkg::CHAN_FIELD_BITS-1:sbfr_pkg::BYTE_BITS]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_time_ff   <= sbfr_pkg::GAP_RESET;
         header_ff     <= sbfr_pkg::HEADER_RESET;
         in_frame_ff   <= 1'b0;
         gap_start_ff  <= '0;
         byte_count_ff <= '0;
      end else begin
         gap_time_ff   <= gap_time_in;
         header_ff     <= header_in;
         in_frame_ff   <= in_frame_in;
         gap_start_ff  <= gap_start_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

// File: hw/rtl/sbfr_queue.sv
// Two-entry queue of collected frames between front and back end.
`include "sbus_frame_receiver_unit_defines.svh"

module sbfr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sbfr_pkg::frame_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output sbfr_pkg::frame_type pop_data,
   input  logic                pop_ready
);

   sbfr_pkg::frame_type mem_ff [sbfr_pkg::QUEUE_DEPTH];

   logic [sbfr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sbfr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sbfr_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   logic push_fire;
   logic pop_fire;

   assign push_ready = count_ff != sbfr_pkg::QUEUE_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SBFR_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= sbfr_pkg::QUEUE_FULL)
   `SBFR_ASSERT_NEXT(a_count_up, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + 2'd1)
   `SBFR_ASSERT_NEXT(a_count_down, clock, reset, pop_fire && !push_fire, count_ff == $past(count_ff) - 2'd1)

endmodule

// File: hw/rtl/sbfr_back.sv
// Back end: unpacks a queued frame into sixteen channel responses.
`include "sbus_frame_receiver_unit_defines.svh"

module sbfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  sbfr_pkg::frame_type pop_data,
   output logic                pop_ready,
   sbfr_rsp_if.source          rsp_bus
);

   sbfr_pkg::back_state_type             state_ff, state_in;
   logic [sbfr_pkg::CHAN_FIELD_BITS-1:0] chans_ff, chans_in;
   logic [sbfr_pkg::FLAG_BITS-1:0]       flags_ff, flags_in;
   logic [sbfr_pkg::CHAN_INDEX_BITS-1:0] index_ff, index_in;

   logic rsp_fire;
   logic last_chan;
   logic load;

   assign last_chan = index_ff == sbfr_pkg::LAST_CHANNEL;
   assign rsp_fire  = (state_ff == sbfr_pkg::BACK_EMIT) && rsp_bus.ready;
   assign pop_ready = (state_ff == sbfr_pkg::BACK_IDLE) || (rsp_fire && last_chan);
   assign load      = pop_valid && pop_ready;

   assign rsp_bus.valid         = state_ff == sbfr_pkg::BACK_EMIT;
   assign rsp_bus.channel_index = index_ff;
   assign rsp_bus.channel_value = chans_ff[sbfr_pkg::CHAN_BITS-1:0];
   assign rsp_bus.digital_one   = flags_ff[0];
   assign rsp_bus.digital_two   = flags_ff[1];
   assign rsp_bus.frame_lost    = flags_ff[2];
   assign rsp_bus.failsafe      = flags_ff[3];
   assign rsp_bus.last_of_frame = last_chan;

   always_comb begin
      state_in = state_ff;
      chans_in = chans_ff;
      flags_in = flags_ff;
      index_in = index_ff;
      unique case (state_ff)
         sbfr_pkg::BACK_IDLE: begin
            if (load) begin
               state_in = sbfr_pkg::BACK_EMIT;
            end
         end
         sbfr_pkg::BACK_EMIT: begin
            if (rsp_fire) begin
               if (last_chan) begin
                  state_in = load ? sbfr_pkg::BACK_EMIT : sbfr_pkg::BACK_IDLE;
               end else begin
                  index_in = index_ff + 1'b1;
                  chans_in = {{sbfr_pkg::CHAN_BITS{1'b0}},
                              chans_ff[sbfr_pkg::CHAN_FIELD_BITS-1:sbfr_pkg::CHAN_BITS]};
               end
            end
         end
         default: state_in = sbfr_pkg::BACK_IDLE;
      endcase
      if (load) begin
         chans_in = pop_data.chans;
         flags_in = pop_data.flags;
         index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbfr_pkg::BACK_IDLE;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      chans_ff <= chans_in;
      flags_ff <= flags_in;
   end

   `SBFR_ASSERT_NEXT(a_index_step, clock, reset, rsp_fire && !last_chan, rsp_bus.valid && (index_ff == $past(index_ff) + 4'd1))
   `SBFR_ASSERT_NEXT(a_load_start, clock, reset, load, rsp_bus.valid && (index_ff == '0))
   `SBFR_ASSERT_NEXT(a_idle_hold, clock, reset, (state_ff == sbfr_pkg::BACK_IDLE) && !pop_valid, state_ff == sbfr_pkg::BACK_IDLE)

endmodule

// File: bench/sbus_frame_receiver_unit_test.sv
// Self-checking bench for the SBUS frame receiver: byte streams in, predicted channel results out.
module sbus_frame_receiver_unit_test;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [sbfr_pkg::CHAN_INDEX_BITS-1:0] chan_index;
      logic [sbfr_pkg::CHAN_BITS-1:0]       chan_value;
      logic                                 dig_one;
      logic                                 dig_two;
      logic                                 lost;
      logic                                 failsafe;
      logic                                 last;
   } channel_result_type;

   logic clock = 1'b0;
   logic reset;

   sbfr_req_if req_bus ();
   sbfr_rsp_if rsp_bus ();
   sbfr_csr_if csr_bus ();

   sbus_frame_receiver_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // decoder state mirrored by the bench
   logic [sbfr_pkg::GAP_BITS-1:0]  gap_limit    = sbfr_pkg::GAP_RESET;
   logic [sbfr_pkg::BYTE_BITS-1:0] header_value = sbfr_pkg::HEADER_RESET;
   logic                           synced       = 1'b0;
   logic [sbfr_pkg::TIME_BITS-1:0] quiet_start  = '0;
   int                             bytes_held   = 0;
   logic [sbfr_pkg::BYTE_BITS-1:0] frame_bytes [sbfr_pkg::FRAME_BYTES];

   channel_result_type expected_channels [$];

   // stimulus bookkeeping
   logic [sbfr_pkg::TIME_BITS-1:0] last_stamp = '0;
   logic [sbfr_pkg::GAP_BITS-1:0]  cur_gap    = sbfr_pkg::GAP_RESET;
   logic [sbfr_pkg::BYTE_BITS-1:0] cur_header = sbfr_pkg::HEADER_RESET;
   int sender_gap_pct      = 0;
   int receiver_stall_pct  = 0;
   int bytes_pushed        = 0;
   int frames_seen         = 0;
   int results_checked     = 0;
   int mismatches          = 0;
   int stall_cycles        = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic predict_byte(input logic [sbfr_pkg::BYTE_BITS-1:0] rx,
                               input logic [sbfr_pkg::TIME_BITS-1:0] stamp);
      logic [sbfr_pkg::TIME_BITS-1:0]                       elapsed;
      logic [sbfr_pkg::FRAME_BYTES*sbfr_pkg::BYTE_BITS-1:0] packed_frame;
      logic [sbfr_pkg::BYTE_BITS-1:0]                       flags;
      channel_result_type                                   res;
      elapsed = stamp - quiet_start;
      if (!synced) begin
         if (rx == header_value && elapsed > {16'd0, gap_limit}) begin
            synced = 1'b1;
            bytes_held = 0;
         end else begin
            quiet_start = stamp;
         end
      end else begin
         frame_bytes[bytes_held] = rx;
         bytes_held++;
         if (bytes_held == sbfr_pkg::FRAME_BYTES) begin
            for (int i = 0; i < sbfr_pkg::FRAME_BYTES; i++) begin
               packed_frame[i*sbfr_pkg::BYTE_BITS +: sbfr_pkg::BYTE_BITS] = frame_bytes[i];
            end
            flags = frame_bytes[sbfr_pkg::FRAME_BYTES-1];
            for (int ch = 0; ch < sbfr_pkg::NUM_CHANNELS; ch++) begin
               res.chan_index = sbfr_pkg::CHAN_INDEX_BITS'(ch);
               res.chan_value = packed_frame[ch*sbfr_pkg::CHAN_BITS +: sbfr_pkg::CHAN_BITS];
               res.dig_one    = flags[0];
               res.dig_two    = flags[1];
               res.lost       = flags[2];
               res.failsafe   = flags[3];
               res.last       = (ch == sbfr_pkg::NUM_CHANNELS - 1);
               expected_channels.push_back(res);
            end
            quiet_start = stamp;
            synced = 1'b0;
            bytes_held = 0;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_channel();
      channel_result_type want;
      if (expected_channels.size() == 0) begin
         $display("%0t: unexpected channel result, expected none actual index %0d value %0d",
                  $time, rsp_bus.channel_index, rsp_bus.channel_value);
         mismatches++;
      end else begin
         want = expected_channels.pop_front();
         compare_field("channel_index", 32'(want.chan_index), 32'(rsp_bus.channel_index));
         compare_field("channel_value", 32'(want.chan_value), 32'(rsp_bus.channel_value));
         compare_field("digital_one", 32'(want.dig_one), 32'(rsp_bus.digital_one));
         compare_field("digital_two", 32'(want.dig_two), 32'(rsp_bus.digital_two));
         compare_field("frame_lost", 32'(want.lost), 32'(rsp_bus.frame_lost));
         compare_field("failsafe", 32'(want.failsafe), 32'(rsp_bus.failsafe));
         compare_field("last_of_frame", 32'(want.last), 32'(rsp_bus.last_of_frame));
      end
      results_checked++;
      if (rsp_bus.last_of_frame === 1'b1) begin
         frames_seen++;
      end
   endtask

   always @(posedge clock) begin : monitor
      bit progress;
      progress = 1'b0;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == sbfr_pkg::CSR_GAP_TIME) begin
               gap_limit = csr_bus.data;
            end else if (csr_bus.index == sbfr_pkg::CSR_HEADER) begin
               header_value = csr_bus.data[sbfr_pkg::BYTE_BITS-1:0];
            end
            progress = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.rx_byte, req_bus.arrival_time_us);
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_channel();
            progress = 1'b1;
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("sbus_frame_receiver_unit regression: fail");
      $finish;
   end

   task automatic push_byte(input logic [sbfr_pkg::BYTE_BITS-1:0] rx,
                            input logic [sbfr_pkg::TIME_BITS-1:0] stamp);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.rx_byte         <= rx;
      req_bus.arrival_time_us <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      last_stamp = stamp;
      bytes_pushed++;
   endtask

   task automatic write_register(input sbfr_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // hold requests until every predicted channel has come out
   task automatic drain_channels();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_channels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [sbfr_pkg::GAP_BITS-1:0] gap,
                                input logic [sbfr_pkg::BYTE_BITS-1:0] hdr);
      write_register(sbfr_pkg::CSR_GAP_TIME, gap);
      write_register(sbfr_pkg::CSR_HEADER, {8'($urandom_range(0, 255)), hdr});
      write_register(sbfr_pkg::csr_index_type'($urandom_range(2, 255)), 16'($urandom));
      cur_gap = gap;
      cur_header = hdr;
   endtask

   task automatic run_frame_traffic(input int byte_budget);
      int                             sent;
      int                             noise;
      bit                             broken;
      logic [sbfr_pkg::BYTE_BITS-1:0] rx;
      logic [sbfr_pkg::TIME_BITS-1:0] stamp;
      sent = 0;
      while (sent < byte_budget) begin
         noise = $urandom_range(0, 3);
         repeat (noise) begin
            rx = 8'($urandom_range(0, 255));
            if (rx == cur_header) begin
               rx ^= 8'h01;
            end
            case ($urandom_range(0, 9))
               0: begin
                  stamp = $urandom;
               end
               1: begin
                  stamp = 32'hFFFF_FFFF - $urandom_range(0, 600);
               end
               default: begin
                  stamp = last_stamp + $urandom_range(1, 300);
               end
            endcase
            push_byte(rx, stamp);
            sent++;
         end
         broken = ($urandom_range(0, 7) == 0);
         if (broken) begin
            stamp = last_stamp + $urandom_range(0, cur_gap);
         end else begin
            stamp = last_stamp + cur_gap + 1 + $urandom_range(0, 500);
         end
         push_byte(cur_header, stamp);
         sent++;
         if (!broken) begin
            for (int i = 0; i < sbfr_pkg::FRAME_BYTES; i++) begin
               case ($urandom_range(0, 5))
                  0: rx = 8'h00;
                  1: rx = 8'hFF;
                  2: rx = cur_header;
                  default: rx = 8'($urandom_range(0, 255));
               endcase
               push_byte(rx, last_stamp + $urandom_range(0, 200));
               sent++;
            end
         end
      end
   endtask

   // quiet-time boundary, wrap of the time stamp, header values inside a frame
   task automatic test_gap_boundary_frame();
      logic [sbfr_pkg::BYTE_BITS-1:0] rx;
      push_byte(8'h00, 32'hFFFF_FFFF);
      push_byte(sbfr_pkg::HEADER_RESET, 32'd1999);
      push_byte(sbfr_pkg::HEADER_RESET, 32'd4000);
      for (int i = 0; i < sbfr_pkg::FRAME_BYTES; i++) begin
         case (i % 3)
            0: rx = 8'hFF;
            1: rx = 8'h00;
            default: rx = sbfr_pkg::HEADER_RESET;
         endcase
         if (i == sbfr_pkg::FRAME_BYTES - 1) begin
            rx = 8'hFF;
         end
         push_byte(rx, last_stamp + 100);
      end
      drain_channels();
   endtask

   task automatic test_unmapped_register();
      write_register(sbfr_pkg::csr_index_type'(8'hFF), 16'hFFFF);
      write_register(sbfr_pkg::csr_index_type'(8'h02), 16'h0000);
   endtask

   task automatic test_traffic_phase(input int send_pct, input int recv_pct, input int budget);
      sender_gap_pct = send_pct;
      receiver_stall_pct = recv_pct;
      drain_channels();
      apply_setting(16'd0, 8'h00);
      run_frame_traffic(budget / 4);
      drain_channels();
      apply_setting(16'hFFFF, 8'hFF);
      run_frame_traffic(budget / 4);
      drain_channels();
      apply_setting(16'($urandom), 8'($urandom));
      run_frame_traffic(budget / 4);
      drain_channels();
      apply_setting(sbfr_pkg::GAP_RESET, sbfr_pkg::HEADER_RESET);
      run_frame_traffic(budget / 4);
      drain_channels();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      req_bus.arrival_time_us = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      sender_gap_pct = 21;
      receiver_stall_pct = 70;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_gap_boundary_frame();
      test_unmapped_register();
      test_traffic_phase(21, 70, 150);
      test_traffic_phase(70, 21, 150);
      test_traffic_phase(0, 0, 150);
      repeat (32) @(posedge clock);

      $display("covered %0d bytes, %0d frames, %0d channel results checked",
               bytes_pushed, frames_seen, results_checked);
      $display("gap 0..65535, header 0x00..0xFF, unmapped writes, early and wrapped headers");
      if (mismatches == 0) begin
         $display("sbus_frame_receiver_unit regression: pass");
      end else begin
         $display("sbus_frame_receiver_unit regression: fail");
      end
      $finish;
   end

endmodule
